/* rtl/dbpg_pkg.sv */
`timescale 1ns / 1ps

package dbpg_pkg;

  localparam int ALPHABET = 62;
  localparam logic [7:0] SYM_MAX = 8'(ALPHABET - 1);
  localparam logic [31:0] WORD_MAX = {4{SYM_MAX}};

  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SYMBOL_LIMIT   = 2'd0,
    CFG_WRAP_SKIP_ZERO = 2'd1,
    CFG_MATCH_ENABLE   = 2'd2,
    CFG_MATCH_PATTERN  = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [31:0] symbol_limit;
    logic        wrap_skip_zero;
    logic        match_enable;
    logic [31:0] match_pattern;
  } cfg_t;

  // One planned item's worth of results, front to back.
  typedef struct packed {
    logic             status;    // single result, no symbol
    logic [3:0][7:0]  syms;      // symbols in emission order
    logic [1:0]       last_idx;  // index of the final symbol
    logic             hit;       // final symbol completes the pattern
    logic [31:0]      pos;       // match start
    logic             fin;       // finished flag on the final result
  } cmd_t;

endpackage

/* rtl/dbpg_if.sv */
`timescale 1ns / 1ps

interface dbpg_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface dbpg_out_if;
  logic        valid;
  logic        ready;
  logic        symbol_valid;
  logic [7:0]  symbol;
  logic        found;
  logic [31:0] match_position;
  logic        finished;
  logic        last;

  modport source (output valid, output symbol_valid, output symbol, output found,
                  output match_position, output finished, output last, input ready);
  modport sink   (input valid, input symbol_valid, input symbol, input found,
                  input match_position, input finished, input last, output ready);
endinterface

/* rtl/dbpg_queue.sv */
`timescale 1ns / 1ps

module dbpg_queue #(
  parameter int DEPTH = dbpg_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  dbpg_pkg::cmd_t  push_data,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output dbpg_pkg::cmd_t  head
);
  import dbpg_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = entry_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* rtl/dbpg_front.sv */
`timescale 1ns / 1ps

module dbpg_front (
  input  logic            clk,
  input  logic            rst_n,
  dbpg_in_if.sink         in_ch,
  input  dbpg_pkg::cfg_t  cfg,
  input  logic            q_full,
  output logic            q_push,
  output dbpg_pkg::cmd_t  q_data
);
  import dbpg_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_PLAN   = 3'b100
  } state_t;

  // next prenecklace candidate: strip trailing zeros, decrement, repeat prefix
  function automatic logic [31:0] next_cand(input logic [31:0] w);
    logic [7:0] b3, b2, b1, b0;
    logic [31:0] c;
    b3 = w[31:24];
    b2 = w[23:16];
    b1 = w[15:8];
    b0 = w[7:0];
    if (b0 != 8'd0) begin
      c = {b3, b2, b1, b0 - 8'd1};
    end else if (b1 != 8'd0) begin
      b1 = b1 - 8'd1;
      c = {b3, b2, b1, b3};
    end else if (b2 != 8'd0) begin
      b2 = b2 - 8'd1;
      c = {b3, b2, b3, b2};
    end else begin
      b3 = b3 - 8'd1;
      c = {b3, b3, b3, b3};
    end
    return c;
  endfunction

  function automatic logic is_neck(input logic [31:0] w);
    logic [31:0] r1, r2, r3;
    r1 = {w[23:0], w[31:24]};
    r2 = {w[15:0], w[31:16]};
    r3 = {w[7:0], w[31:8]};
    return !((r1 > w) || (r2 > w) || (r3 > w));
  endfunction

  state_t      state_r;
  logic [31:0] neck_r, cand_r, recent_r, count_r, budget_r;
  logic        done_r, first_r, initial_r;

  logic        accept;
  logic [31:0] cand, found_word;
  logic        found;

  // plan signals
  logic [2:0]       period, cnt, n;
  logic [1:0]       bidx;
  logic [3:0][7:0]  syms;
  logic [3:0][31:0] rec;
  logic [31:0]      r, cntk, pos;
  logic [31:0]      count_plan, budget_plan, recent_plan;
  logic             hit, done_plan;

  assign in_ch.ready = (state_r == ST_IDLE) && !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  // one successor try per cycle
  always_comb begin
    cand       = next_cand(cand_r);
    found      = 1'b0;
    found_word = cand;
    if (cand_r == 32'd0) begin
      found      = 1'b1;
      found_word = WORD_MAX;
    end else if (is_neck(cand)) begin
      found = 1'b1;
      if (cfg.wrap_skip_zero && (cand == 32'd0)) begin
        found_word = WORD_MAX;
      end
    end
  end

  always_comb begin
    if ((neck_r[31:24] == neck_r[7:0]) && (neck_r[23:16] == neck_r[7:0]) &&
        (neck_r[15:8] == neck_r[7:0])) begin
      period = 3'd1;
    end else if (neck_r[31:16] == neck_r[15:0]) begin
      period = 3'd2;
    end else begin
      period = 3'd4;
    end
    cnt = (budget_r < 32'(period)) ? budget_r[2:0] : period;

    r    = recent_r;
    hit  = 1'b0;
    n    = cnt;
    pos  = '0;
    cntk = '0;
    for (int k = 0; k < 4; k++) begin
      bidx    = 2'(cnt - 3'(k + 1));
      syms[k] = neck_r[8*bidx +: 8];
      r       = {r[23:0], syms[k]};
      rec[k]  = r;
      cntk    = count_r + 32'(k + 1);
      if (!hit && (3'(k + 1) <= cnt) && cfg.match_enable && (cntk >= 32'd4) &&
          (r == cfg.match_pattern)) begin
        hit = 1'b1;
        n   = 3'(k + 1);
        pos = cntk - 32'd4;
      end
    end
    recent_plan = rec[2'(n - 3'd1)];
    count_plan  = count_r + 32'(n);
    budget_plan = budget_r - 32'(n);
    done_plan   = hit || (budget_plan == 32'd0) ||
                  (cfg.match_enable && !initial_r && (neck_r == WORD_MAX));
  end

  always_comb begin
    q_push          = 1'b0;
    q_data          = '0;
    q_data.syms     = syms;
    q_data.last_idx = 2'(n - 3'd1);
    q_data.hit      = hit;
    q_data.pos      = pos;
    q_data.fin      = done_plan;
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_ch.restart || done_r)) begin
          q_push        = 1'b1;
          q_data        = '0;
          q_data.status = 1'b1;
          q_data.fin    = in_ch.restart ? (cfg.symbol_limit == 32'd0) : 1'b1;
        end
      end
      ST_PLAN: begin
        q_push = !q_full;
      end
      default: begin
        q_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      neck_r    <= WORD_MAX;
      recent_r  <= '1;
      count_r   <= '0;
      budget_r  <= '0;
      done_r    <= 1'b1;
      first_r   <= 1'b0;
      initial_r <= 1'b0;
      cand_r    <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            if (in_ch.restart) begin
              neck_r   <= WORD_MAX;
              recent_r <= '1;
              count_r  <= '0;
              budget_r <= cfg.symbol_limit;
              first_r  <= 1'b1;
              done_r   <= (cfg.symbol_limit == 32'd0);
            end else if (!done_r) begin
              if (first_r) begin
                first_r   <= 1'b0;
                initial_r <= 1'b1;
                state_r   <= ST_PLAN;
              end else begin
                cand_r    <= neck_r;
                initial_r <= 1'b0;
                state_r   <= ST_SEARCH;
              end
            end
          end
        end
        ST_SEARCH: begin
          if (found) begin
            neck_r  <= found_word;
            state_r <= ST_PLAN;
          end else begin
            cand_r <= cand;
          end
        end
        ST_PLAN: begin
          if (!q_full) begin
            recent_r <= recent_plan;
            count_r  <= count_plan;
            budget_r <= budget_plan;
            done_r   <= done_plan;
            state_r  <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/dbpg_back.sv */
`timescale 1ns / 1ps

module dbpg_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            head_valid,
  input  dbpg_pkg::cmd_t  head,
  output logic            pop,
  dbpg_out_if.source      out_ch
);
  import dbpg_pkg::*;

  logic [1:0]  idx_r;
  logic        out_valid_r;
  logic        sym_valid_r, found_r, fin_r, last_r;
  logic [7:0]  symbol_r;
  logic [31:0] pos_r;
  logic        load, is_last;

  assign load    = head_valid && (!out_valid_r || out_ch.ready);
  assign is_last = head.status || (idx_r == head.last_idx);
  assign pop     = load && is_last;

  assign out_ch.valid          = out_valid_r;
  assign out_ch.symbol_valid   = sym_valid_r;
  assign out_ch.symbol         = symbol_r;
  assign out_ch.found          = found_r;
  assign out_ch.match_position = pos_r;
  assign out_ch.finished       = fin_r;
  assign out_ch.last           = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        idx_r       <= is_last ? 2'd0 : idx_r + 2'd1;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sym_valid_r <= !head.status;
      symbol_r    <= head.status ? 8'd0 : head.syms[idx_r];
      found_r     <= !head.status && is_last && head.hit;
      pos_r       <= (!head.status && is_last && head.hit) ? head.pos : 32'd0;
      fin_r       <= is_last && head.fin;
      last_r      <= is_last;
    end
  end

endmodule

/* rtl/de_bruijn_pattern_generator.sv */
`timescale 1ns / 1ps
// Channel   Dir  Handshake         Payload
// in_ch     in   valid/ready       restart
// out_ch    out  valid/ready       symbol_valid symbol found match_position finished last
// cfg_*     in   cfg_we (no wait)  cfg_index cfg_wdata
//
// Restart, and an advance once finished: the front pushes one status result from idle.
// Advance: the front steps from idle through search (skipped on the first advance)
// to plan; the back then sends one result per cycle while out_ch is ready.
// Reset (synchronous, rst_n low): finished until the first restart; config to defaults.
// QUEUE_DEPTH planned items sit between front and back, so either side may stall alone.

module de_bruijn_pattern_generator #(
  parameter int QUEUE_DEPTH = dbpg_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  dbpg_in_if.sink                         in_ch,
  dbpg_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [dbpg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dbpg_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import dbpg_pkg::*;

  cfg_t cfg_r;

  logic q_push, q_full, q_pop, q_head_valid;
  cmd_t q_data, q_head;

  // Register file; symbol_limit is only sampled by the front on restart.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.symbol_limit   <= '1;
      cfg_r.wrap_skip_zero <= 1'b0;
      cfg_r.match_enable   <= 1'b0;
      cfg_r.match_pattern  <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SYMBOL_LIMIT:   cfg_r.symbol_limit   <= cfg_wdata[31:0];
        CFG_WRAP_SKIP_ZERO: cfg_r.wrap_skip_zero <= cfg_wdata[0];
        CFG_MATCH_ENABLE:   cfg_r.match_enable   <= cfg_wdata[0];
        CFG_MATCH_PATTERN:  cfg_r.match_pattern  <= cfg_wdata[31:0];
        default: begin
        end
      endcase
    end
  end

  // Front: takes items, runs the necklace search and plans each item's results.
  dbpg_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg    (cfg_r),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_data)
  );

  dbpg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_data),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  // Back: serialises a plan into results through the output register.
  dbpg_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .out_ch     (out_ch)
  );

endmodule

/* rtl/dbpg_checker.sv */
`timescale 1ns / 1ps

module dbpg_port_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_symbol_valid,
  input logic [7:0]  out_symbol,
  input logic        out_found,
  input logic [31:0] out_match_position,
  input logic        out_finished,
  input logic        out_last
);
  import dbpg_pkg::*;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_symbol) &&
    $stable(out_last) && $stable(out_found))
    else $error("result changed while stalled");

  a_found_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_last && out_finished && out_symbol_valid)
    else $error("match not on a finishing final result");

  a_status_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_symbol_valid |-> out_last && (out_symbol == 8'd0))
    else $error("status result malformed");

  a_symbol_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_symbol_valid |-> (int'(out_symbol) < ALPHABET))
    else $error("symbol outside alphabet");

  a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> (out_match_position == 32'd0))
    else $error("match position set without a match");

endmodule

bind de_bruijn_pattern_generator dbpg_port_checker u_dbpg_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_symbol_valid   (out_ch.symbol_valid),
  .out_symbol         (out_ch.symbol),
  .out_found          (out_ch.found),
  .out_match_position (out_ch.match_position),
  .out_finished       (out_ch.finished),
  .out_last           (out_ch.last)
);

/* tb/dbpg_checker.sv */
`timescale 1ns / 1ps

module dbpg_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic                            in_restart,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic                            out_symbol_valid,
  input  logic [7:0]                      out_symbol,
  input  logic                            out_found,
  input  logic [31:0]                     out_match_position,
  input  logic                            out_finished,
  input  logic                            out_last,
  input  logic                            cfg_we,
  input  logic [dbpg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dbpg_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              fail_count,
  output int                              results_due,
  output int                              symbols_seen,
  output int                              matches_seen
);
  import dbpg_pkg::*;

  typedef struct packed {
    logic        sym_valid;
    logic [7:0]  sym;
    logic        hit;
    logic [31:0] pos;
    logic        fin;
    logic        lst;
  } sym_result_t;

  sym_result_t symbols_due[$];

  // register copies
  logic [31:0] limit_r;
  logic        skip_zero_r;
  logic        search_r;
  logic [31:0] pattern_r;

  // generator state
  logic [31:0] neck_q;
  logic [31:0] hist_q;
  logic [31:0] emitted_q;
  logic [31:0] budget_q;
  logic        halted_q;
  logic        first_due_q;

  function automatic bit is_max_rot(logic [31:0] w);
    logic [31:0] r;
    for (int k = 1; k < 4; k++) begin
      r = (w << (8 * k)) | (w >> (32 - 8 * k));
      if (r > w) return 1'b0;
    end
    return 1'b1;
  endfunction

  // next smaller necklace; all-zero wraps to all-maximum
  function automatic logic [31:0] succ_word(logic [31:0] w);
    int used;
    int t;
    while (1) begin
      if (w == 32'd0) return WORD_MAX;
      used = 4;
      while (w[7:0] == 8'd0) begin
        w = w >> 8;
        used--;
      end
      w = w - 32'd1;
      while (used < 4) begin
        t = 4 - used;
        if (t > used) t = used;
        w = (w << (8 * t)) | (w >> (8 * (used - t)));
        used += t;
      end
      if (is_max_rot(w)) return w;
    end
  endfunction

  function automatic int period_of(logic [31:0] w);
    if (w[15:8] == w[7:0] && w[23:16] == w[7:0] && w[31:24] == w[7:0]) return 1;
    if (w[31:16] == w[15:0]) return 2;
    return 4;
  endfunction

  function automatic sym_result_t status_result(logic fin);
    sym_result_t r;
    r = '0;
    r.fin = fin;
    r.lst = 1'b1;
    return r;
  endfunction

  task automatic walk_necklace(input logic restart);
    sym_result_t batch [4];
    logic [31:0] nk;
    logic [7:0]  s;
    logic        h;
    logic        opening;
    int          cnt;
    int          n;
    n = 0;
    if (restart) begin
      neck_q      = WORD_MAX;
      hist_q      = '1;
      emitted_q   = '0;
      budget_q    = limit_r;
      first_due_q = 1'b1;
      halted_q    = (limit_r == 32'd0);
      symbols_due.push_back(status_result(halted_q));
      return;
    end
    if (halted_q) begin
      symbols_due.push_back(status_result(1'b1));
      return;
    end
    if (first_due_q) begin
      nk          = neck_q;
      first_due_q = 1'b0;
      opening     = 1'b1;
    end else begin
      nk = succ_word(neck_q);
      if (skip_zero_r && nk == 32'd0) nk = WORD_MAX;
      opening = 1'b0;
    end
    neck_q = nk;
    cnt = period_of(nk);
    if (budget_q < cnt) cnt = budget_q;
    // budget clip keeps the tail of the necklace
    for (int j = cnt; j > 0; j--) begin
      s = nk[8 * (j - 1) +: 8];
      hist_q = {hist_q[23:0], s};
      emitted_q++;
      budget_q--;
      h = search_r && emitted_q >= 32'd4 && hist_q == pattern_r;
      batch[n] = '0;
      batch[n].sym_valid = 1'b1;
      batch[n].sym = s;
      batch[n].hit = h;
      batch[n].pos = h ? emitted_q - 32'd4 : 32'd0;
      n++;
      if (h) begin
        halted_q = 1'b1;
        break;
      end
    end
    if (!halted_q) begin
      if (budget_q == 32'd0) halted_q = 1'b1;
      else if (search_r && !opening && nk == WORD_MAX) halted_q = 1'b1;
    end
    batch[n - 1].fin = halted_q;
    batch[n - 1].lst = 1'b1;
    for (int i = 0; i < n; i++) symbols_due.push_back(batch[i]);
  endtask

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s: got %0h, expected %0h", name, got, want));
  endtask

  task automatic check_result();
    sym_result_t want;
    if (symbols_due.size() == 0) begin
      report_mismatch($sformatf("item with nothing expected (symbol_valid %0b symbol %0d)",
                                out_symbol_valid, out_symbol));
      return;
    end
    want = symbols_due.pop_front();
    check_field("symbol_valid", 32'(out_symbol_valid), 32'(want.sym_valid));
    check_field("symbol", 32'(out_symbol), 32'(want.sym));
    check_field("found", 32'(out_found), 32'(want.hit));
    check_field("match_position", out_match_position, want.pos);
    check_field("finished", 32'(out_finished), 32'(want.fin));
    check_field("last", 32'(out_last), 32'(want.lst));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      limit_r      = '1;
      skip_zero_r  = 1'b0;
      search_r     = 1'b0;
      pattern_r    = '0;
      neck_q       = WORD_MAX;
      hist_q       = '1;
      emitted_q    = '0;
      budget_q     = '0;
      halted_q     = 1'b1;
      first_due_q  = 1'b0;
      fail_count   = 0;
      symbols_seen = 0;
      matches_seen = 0;
      symbols_due.delete();
      results_due <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (out_symbol_valid) symbols_seen++;
        if (out_found) matches_seen++;
        check_result();
      end
      if (in_valid && in_ready) walk_necklace(in_restart);
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_SYMBOL_LIMIT:   limit_r = cfg_wdata;
          CFG_WRAP_SKIP_ZERO: skip_zero_r = cfg_wdata[0];
          CFG_MATCH_ENABLE:   search_r = cfg_wdata[0];
          CFG_MATCH_PATTERN:  pattern_r = cfg_wdata;
          default: ;
        endcase
      end
      results_due <= symbols_due.size();
    end
  end

endmodule

/* tb/tb_de_bruijn_pattern_generator.sv */
`timescale 1ns / 1ps

module tb_de_bruijn_pattern_generator;
  import dbpg_pkg::*;

  localparam int CLK_PERIOD   = 8;
  localparam int CYCLE_LIMIT  = 200000;  // watchdog bound on the whole run
  localparam int DRAIN_CYCLES = 20;      // a few successor tries plus a full necklace
  localparam int RANDOM_ITEMS = 120;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  dbpg_in_if  in_ch ();
  dbpg_out_if out_ch ();

  int chk_fails;
  int chk_due;
  int chk_symbols;
  int chk_matches;

  int items_sent;
  int restarts_sent;
  int random_items;
  int burst_left;
  int cycle_count;

  always #(CLK_PERIOD / 2) clk = ~clk;

  de_bruijn_pattern_generator u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  dbpg_checker u_chk (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_ch.valid),
    .in_ready           (in_ch.ready),
    .in_restart         (in_ch.restart),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .out_symbol_valid   (out_ch.symbol_valid),
    .out_symbol         (out_ch.symbol),
    .out_found          (out_ch.found),
    .out_match_position (out_ch.match_position),
    .out_finished       (out_ch.finished),
    .out_last           (out_ch.last),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .fail_count         (chk_fails),
    .results_due        (chk_due),
    .symbols_seen       (chk_symbols),
    .matches_seen       (chk_matches)
  );

  // Watchdog: a hung handshake ends the run here.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("ERROR: run stopped after %0d cycles, %0d results outstanding",
                 cycle_count, chk_due);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // Result side back-pressure. The pattern is redrawn periodically from
  // always ready, mostly ready, mostly stalled and a fixed on/off rhythm, so
  // stalls land on every slot of a four-symbol necklace.
  initial begin
    int stall_mode;
    int tick;
    stall_mode = 0;
    tick = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (tick % 64 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0:       out_ch.ready <= 1'b1;
        1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
        2:       out_ch.ready <= ($urandom_range(0, 2) == 0);
        default: out_ch.ready <= tick[2];
      endcase
    end
  end

  // Offer one item and hold it until taken. The sender then either carries
  // on within its burst (valid stays high) or drops valid for a short gap.
  task automatic send_item(input logic restart);
    in_ch.valid   <= 1'b1;
    in_ch.restart <= restart;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    items_sent++;
    if (restart) restarts_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      // now and then a long unbroken stretch
      burst_left = ($urandom_range(0, 5) == 0) ? 30 : $urandom_range(0, 8);
      if ($urandom_range(0, 2) != 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  endtask

  // Stop offering and wait until every predicted item has come back, then
  // allow for the successor search of anything still in flight.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (chk_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // All four registers, back to back, only with the block drained.
  task automatic set_config(input logic [31:0] limit, input logic skip_zero,
                            input logic search, input logic [31:0] pattern);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SYMBOL_LIMIT;
    cfg_wdata <= limit;
    @(posedge clk);
    cfg_index <= CFG_WRAP_SKIP_ZERO;
    cfg_wdata <= 32'(skip_zero);
    @(posedge clk);
    cfg_index <= CFG_MATCH_ENABLE;
    cfg_wdata <= 32'(search);
    @(posedge clk);
    cfg_index <= CFG_MATCH_PATTERN;
    cfg_wdata <= pattern;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // A pattern that the early sequence actually contains: a window over
  // "max max max k", rotated so the hit can fall on any necklace slot.
  function automatic logic [31:0] reachable_pattern();
    logic [31:0] base;
    int          rot;
    base = {SYM_MAX, SYM_MAX, SYM_MAX, 8'($urandom_range(45, 60))};
    rot  = $urandom_range(0, 3);
    return (base << (8 * rot)) | (base >> (32 - 8 * rot));
  endfunction

  initial begin
    logic [31:0] limit;
    logic [31:0] pattern;
    int          sel;
    int          run_len;

    items_sent    = 0;
    restarts_sent = 0;
    random_items  = 0;
    burst_left    = 0;
    in_ch.valid   <= 1'b0;
    in_ch.restart <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_SYMBOL_LIMIT;
    cfg_wdata     <= '0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed part ----

    // Out of reset the block is finished: an advance only gets a status item.
    send_item(1'b0);
    // Default full budget: the lone max symbol, then full four-symbol necklaces.
    send_item(1'b1);
    repeat (4) send_item(1'b0);

    // Zero budget finishes on the restart itself.
    set_config(32'd0, 1'b0, 1'b0, 32'd0);
    send_item(1'b1);
    send_item(1'b0);

    // Budget of three: one symbol, then a necklace clipped to its last two.
    set_config(32'd3, 1'b0, 1'b0, 32'd0);
    send_item(1'b1);
    repeat (3) send_item(1'b0);

    // Pattern equal to the reset history with one symbol shifted in: must not
    // hit while fewer than four symbols have gone out.
    set_config('1, 1'b0, 1'b1, {8'hFF, 8'hFF, 8'hFF, SYM_MAX});
    send_item(1'b1);
    repeat (2) send_item(1'b0);

    // All-max pattern hits inside the second necklace; its tail is dropped.
    set_config('1, 1'b1, 1'b1, {4{SYM_MAX}});
    send_item(1'b1);
    repeat (3) send_item(1'b0);

    // Budget ends on the very symbol that matches: the match wins.
    set_config(32'd5, 1'b0, 1'b1, {SYM_MAX, SYM_MAX, SYM_MAX, SYM_MAX - 8'd1});
    send_item(1'b1);
    repeat (2) send_item(1'b0);

    // Search switched on in the middle of a run; the budget is not reloaded.
    set_config(32'd40, 1'b0, 1'b0, '0);
    send_item(1'b1);
    repeat (2) send_item(1'b0);
    set_config(32'd2, 1'b0, 1'b1, {SYM_MAX, SYM_MAX, SYM_MAX - 8'd3, SYM_MAX});
    repeat (5) send_item(1'b0);

    // ---- random part ----
    // Each phase: fresh settings, a restart, then a run of advances. A few
    // runs are cut by a stray restart and a few go on past their finish.
    while (random_items < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 9);
      case (sel)
        0:       limit = 32'd0;
        1:       limit = '1;
        2:       limit = $urandom;
        default: limit = $urandom_range(1, 60);
      endcase
      sel = $urandom_range(0, 9);
      if (sel < 6)       pattern = reachable_pattern();
      else if (sel == 6) pattern = {4{SYM_MAX}};
      else               pattern = $urandom;
      set_config(limit, 1'($urandom_range(0, 1)), ($urandom_range(0, 3) != 0), pattern);

      send_item(1'b1);
      random_items++;
      run_len = $urandom_range(2, 24);
      repeat (run_len) begin
        send_item($urandom_range(0, 19) == 0);
        random_items++;
        // occasionally let everything drain mid-run
        if ($urandom_range(0, 15) == 0) wait_idle();
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d items (%0d restarts, %0d random), %0d symbols, %0d matches",
             items_sent, restarts_sent, random_items, chk_symbols, chk_matches);
    $display("Budgets from zero to full, clipped necklaces, search on and off");
    if (chk_fails == 0 && chk_due == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches, %0d results outstanding", chk_fails, chk_due);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
